// File: hw/rtl/tlpm_pkg.sv
// shared types and constants for the two-level page map insert block
// no dependencies; imported by every module of the block except tlpm_ram
`timescale 1ns / 1ps

package tlpm_pkg;

  localparam int unsigned MAX_TABLES_DEF    = 64;
  localparam int unsigned ENTRIES_PER_TABLE = 1024;
  localparam int unsigned DIR_ENTRIES       = 1024;
  localparam int unsigned DIR_IX_W          = 10;
  localparam int unsigned TIX_W             = 10;
  localparam int unsigned ENTRY_W           = 32;
  localparam int unsigned ATTR_W            = 12;
  localparam int unsigned SLOT_MAX_W        = 10;
  localparam int unsigned PAGE_SHIFT        = 12;
  localparam int unsigned DIR_IX_LSB        = 22;
  localparam int unsigned TIX_LSB           = 12;

  // present, user, writable
  localparam logic [ENTRY_W-1:0] DIR_FLAGS = 32'h0000_0007;

  typedef enum logic [1:0] {
    ST_WRITTEN   = 2'd0,
    ST_KEPT      = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  // classified request handed from the front part to the back part
  typedef struct packed {
    logic                  exhausted;
    logic                  allocated;
    logic [SLOT_MAX_W-1:0] slot;
    logic [TIX_W-1:0]      tix;
    logic [ENTRY_W-1:0]    value;
  } req_t;

  typedef enum logic [1:0] {
    F_CLEAR,
    F_IDLE,
    F_LOOK
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ZERO,
    B_READ,
    B_WAIT
  } back_state_t;

endpackage

// File: hw/rtl/tlpm_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module tlpm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tlpm_fifo.sv
// two-entry queue of classified requests between front and back parts
// depends on tlpm_pkg
`timescale 1ns / 1ps

module tlpm_fifo import tlpm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t data_in,
  output logic full,
  input  logic pop,
  output req_t data_out,
  output logic empty
);

  req_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign data_out = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/tlpm_front.sv
// front part: accepts map requests, looks up the page directory and allocates tables
// depends on tlpm_pkg and tlpm_ram
`timescale 1ns / 1ps

module tlpm_front import tlpm_pkg::*; #(
  parameter int unsigned MAX_TABLES = MAX_TABLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        linear_address,
  input  logic [31:0]        physical_address,
  input  logic [ATTR_W-1:0]  entry_attributes,
  input  logic [ENTRY_W-1:0] table_base,
  input  logic               q_full,
  output logic               q_push,
  output req_t               q_data
);

  localparam int unsigned SLOT_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TABLES + 1);
  localparam int unsigned DIR_W  = SLOT_W + ENTRY_W;

  front_state_t        state;
  front_state_t        state_next;
  logic [DIR_IX_W-1:0] clr_cnt;
  logic [CNT_W-1:0]    next_slot;
  logic [DIR_IX_W-1:0] dix;
  logic [TIX_W-1:0]    tix;
  logic [ENTRY_W-1:0]  value;

  logic                accept;
  logic                alloc;
  logic                dir_we;
  logic [DIR_IX_W-1:0] dir_waddr;
  logic [DIR_W-1:0]    dir_wdata;
  logic [DIR_W-1:0]    dir_rdata;
  logic                dir_present;
  logic [SLOT_W-1:0]   new_slot;
  logic [ENTRY_W-1:0]  dir_entry;

  tlpm_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_ENTRIES)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (linear_address[DIR_IX_LSB +: DIR_IX_W]),
    .rdata (dir_rdata)
  );

  assign busy        = (state != F_IDLE) || q_full;
  assign accept      = (state == F_IDLE) && start && !q_full;
  assign dir_present = dir_rdata[0];
  assign new_slot    = next_slot[SLOT_W-1:0];
  assign dir_entry   = (table_base + (ENTRY_W'(new_slot) << PAGE_SHIFT)) | DIR_FLAGS;

  always_comb begin
    state_next = state;
    unique case (state)
      F_CLEAR: begin
        if (clr_cnt == DIR_IX_W'(DIR_ENTRIES - 1)) begin
          state_next = F_IDLE;
        end
      end
      F_IDLE: begin
        if (accept) begin
          state_next = F_LOOK;
        end
      end
      F_LOOK:  state_next = F_IDLE;
      default: state_next = F_CLEAR;
    endcase
  end

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = dix;
    dir_wdata = {new_slot, dir_entry};
    q_push    = 1'b0;
    alloc     = 1'b0;
    q_data    = '{exhausted: 1'b0, allocated: 1'b0, slot: '0, tix: tix, value: value};
    unique case (state)
      F_CLEAR: begin
        dir_we    = 1'b1;
        dir_waddr = clr_cnt;
        dir_wdata = '0;
      end
      F_LOOK: begin
        q_push = 1'b1;
        priority if (dir_present) begin
          q_data.slot = SLOT_MAX_W'(dir_rdata[DIR_W-1:ENTRY_W]);
        end else if (next_slot == CNT_W'(MAX_TABLES)) begin
          q_data.exhausted = 1'b1;
        end else begin
          alloc            = 1'b1;
          dir_we           = 1'b1;
          q_data.allocated = 1'b1;
          q_data.slot      = SLOT_MAX_W'(new_slot);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_CLEAR;
      clr_cnt   <= '0;
      next_slot <= '0;
    end else begin
      state <= state_next;
      if (state == F_CLEAR) begin
        clr_cnt <= clr_cnt + DIR_IX_W'(1);
      end
      if (alloc) begin
        next_slot <= next_slot + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dix   <= linear_address[DIR_IX_LSB +: DIR_IX_W];
      tix   <= linear_address[TIX_LSB +: TIX_W];
      value <= physical_address | ENTRY_W'(entry_attributes);
    end
  end

endmodule

// File: hw/rtl/tlpm_back.sv
// back part: zeroes new tables and does the read-modify-write of the table entry
// depends on tlpm_pkg and tlpm_ram
`timescale 1ns / 1ps

module tlpm_back import tlpm_pkg::*; #(
  parameter int unsigned MAX_TABLES = MAX_TABLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  req_t               q_data,
  output logic               done,
  output logic [1:0]         status,
  output logic               table_allocated,
  output logic [ENTRY_W-1:0] entry_value
);

  localparam int unsigned SLOT_W  = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int unsigned POOL_D  = MAX_TABLES * ENTRIES_PER_TABLE;
  localparam int unsigned POOL_AW = $clog2(POOL_D);

  back_state_t        state;
  back_state_t        state_next;
  req_t               cur;
  logic [TIX_W-1:0]   zcnt;

  logic               done_next;
  status_t            status_next;
  logic               alloc_next;
  logic [ENTRY_W-1:0] value_next;

  logic               pool_we;
  logic [POOL_AW-1:0] pool_waddr;
  logic [ENTRY_W-1:0] pool_wdata;
  logic [POOL_AW-1:0] pool_raddr;
  logic [ENTRY_W-1:0] pool_rdata;

  tlpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_D)
  ) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  assign pool_raddr = POOL_AW'({cur.slot[SLOT_W-1:0], cur.tix});

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty && !q_data.exhausted) begin
          state_next = q_data.allocated ? B_ZERO : B_READ;
        end
      end
      B_ZERO: begin
        if (zcnt == TIX_W'(ENTRIES_PER_TABLE - 1)) begin
          state_next = B_READ;
        end
      end
      B_READ:  state_next = B_WAIT;
      B_WAIT:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    pool_we     = 1'b0;
    pool_waddr  = pool_raddr;
    pool_wdata  = cur.value;
    done_next   = 1'b0;
    status_next = ST_WRITTEN;
    alloc_next  = cur.allocated;
    value_next  = cur.value;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          // exhausted pool needs no memory access
          if (q_data.exhausted) begin
            done_next   = 1'b1;
            status_next = ST_EXHAUSTED;
            alloc_next  = 1'b0;
            value_next  = '0;
          end
        end
      end
      B_ZERO: begin
        pool_we    = 1'b1;
        pool_waddr = POOL_AW'({cur.slot[SLOT_W-1:0], zcnt});
        pool_wdata = '0;
      end
      B_WAIT: begin
        done_next = 1'b1;
        if (pool_rdata[0]) begin
          status_next = ST_KEPT;
          value_next  = pool_rdata;
        end else begin
          pool_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      zcnt  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == B_ZERO) begin
        zcnt <= zcnt + TIX_W'(1);
      end else begin
        zcnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (done_next) begin
      status          <= status_next;
      table_allocated <= alloc_next;
      entry_value     <= value_next;
    end
  end

endmodule

// File: hw/rtl/two_level_page_map_insert.sv
// two-level page map insert: one result per transaction; the front part looks up the
// directory, then the back part pops the request, reads, checks and writes back the pool
// entry and raises done; a table allocation first zeroes the new table, and an exhausted pool
// skips the pool access. New requests are taken before the back part is through with earlier
// ones while the two-entry queue has room. After rst (synchronous, active high) busy stays high
// while the directory is cleared; done is a one-cycle strobe and the receiver cannot stall it
`timescale 1ns / 1ps

module two_level_page_map_insert import tlpm_pkg::*; #(
  parameter int unsigned MAX_TABLES = MAX_TABLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        linear_address,
  input  logic [31:0]        physical_address,
  input  logic [ATTR_W-1:0]  entry_attributes,
  input  logic               table_base_we,
  input  logic [ENTRY_W-1:0] table_base_data,
  output logic               done,
  output logic [1:0]         status,
  output logic               table_allocated,
  output logic [ENTRY_W-1:0] entry_value
);

  logic [ENTRY_W-1:0] table_base;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  req_t               q_in;
  req_t               q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base <= '0;
    end else if (table_base_we) begin
      table_base <= table_base_data;
    end
  end

  tlpm_front #(
    .MAX_TABLES (MAX_TABLES)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .linear_address   (linear_address),
    .physical_address (physical_address),
    .entry_attributes (entry_attributes),
    .table_base       (table_base),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  tlpm_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .data_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .data_out (q_out),
    .empty    (q_empty)
  );

  tlpm_back #(
    .MAX_TABLES (MAX_TABLES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_data          (q_out),
    .done            (done),
    .status          (status),
    .table_allocated (table_allocated),
    .entry_value     (entry_value)
  );

endmodule
